// File: src/cstc_pkg.sv
// Shared types, constants and tables for the callsign token classifier.
package cstc_pkg;

    localparam int CALL_MAX_LEN = 12;
    localparam int KW_COUNT     = 30;
    localparam int KW_MAX       = 4;
    localparam logic [15:0] CONF_ONE = 16'd32768;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic EV_CALLSIGN = 1'b0;
    localparam logic EV_KEYWORD  = 1'b1;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DIVIDE,
        ST_SEARCH,
        ST_INSERT,
        ST_EMIT,
        ST_CLEAR
    } cstc_state_t;

    // Control from the sequencer to the recent-list cell chain.
    typedef struct packed {
        logic search;
        logic shift;
    } cstc_chain_ctl_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_upper(c);
    endfunction

    // Keyword table, each entry right padded with zero bytes.
    function automatic logic [31:0] kw_text(input int k);
        logic [31:0] t;
        case (k)
            0:  t = {"CQ", 16'h0};
            1:  t = {"DE", 16'h0};
            2:  t = "TEST";
            3:  t = {"599", 8'h0};
            4:  t = {"5NN", 8'h0};
            5:  t = {"NR", 16'h0};
            6:  t = {"TU", 16'h0};
            7:  t = {"73", 16'h0};
            8:  t = {"BK", 16'h0};
            9:  t = {"RST", 8'h0};
            10: t = {"QSL", 8'h0};
            11: t = {"QTH", 8'h0};
            12: t = "NAME";
            13: t = {"UR", 16'h0};
            14: t = {"CFM", 8'h0};
            15: t = {"GL", 16'h0};
            16: t = {"AGN", 8'h0};
            17: t = {"QRZ", 8'h0};
            18: t = {"K", 24'h0};
            19: t = {"R", 24'h0};
            20: t = {"OP", 16'h0};
            21: t = {"RIG", 8'h0};
            22: t = {"ANT", 8'h0};
            23: t = {"WX", 16'h0};
            24: t = {"SN", 16'h0};
            25: t = {"TNX", 8'h0};
            26: t = {"GM", 16'h0};
            27: t = {"GA", 16'h0};
            28: t = {"GE", 16'h0};
            29: t = {"FB", 16'h0};
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        logic [31:0] t;
        logic [2:0]  n;
        t = kw_text(k);
        n = 3'd0;
        for (int i = 0; i < KW_MAX; i++)
        begin
            if (t[31 - 8*i -: 8] != 8'h0)
            begin
                n = 3'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: src/cstc_recent_cell.sv
// One entry of the recent-callsign list: holds a word and compares it with the probe.
module cstc_recent_cell #(
    parameter int NCH = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cstc_pkg::cstc_chain_ctl_t   ctl,
    input  logic                        prev_valid,
    input  logic [NCH*8-1:0]            prev_chars,
    input  logic [4:0]                  prev_len,
    input  logic [NCH*8-1:0]            probe_chars,
    input  logic [4:0]                  probe_len,
    output logic                        valid,
    output logic [NCH*8-1:0]            chars,
    output logic [4:0]                  len,
    output logic                        hit
);
    import cstc_pkg::*;

    logic             valid_reg;
    logic [NCH*8-1:0] chars_reg;
    logic [4:0]       len_reg;
    logic             hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.shift)
            begin
                valid_reg <= prev_valid;
            end
            // register the compare so the OR across the row is one level
            hit_reg <= ctl.search && valid_reg && (len_reg == probe_len)
                       && (chars_reg == probe_chars);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            chars_reg <= prev_chars;
            len_reg   <= prev_len;
        end
    end

    assign valid = valid_reg;
    assign chars = chars_reg;
    assign len   = len_reg;
    assign hit   = hit_reg;
endmodule

// File: src/cstc_divider.sv
// Restoring divider: conf_sum over word length, one quotient bit a cycle.
module cstc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [19:0] dividend,
    input  logic [4:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import cstc_pkg::*;

    logic [19:0] q_reg;
    logic [4:0]  r_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  trial;

    assign trial = {r_reg, q_reg[19]} - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            // raise done once the last quotient bit has landed
            done_reg <= busy_reg && (cnt_reg == 5'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd20;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 5'd0;
        end
        else if (busy_reg)
        begin
            if (!trial[5])
            begin
                r_reg <= trial[4:0];
                q_reg <= {q_reg[18:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[3:0], q_reg[19]};
                q_reg <= {q_reg[18:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[15:0];
endmodule

// File: src/callsign_token_classifier.sv
// Top level of the callsign token classifier: word store, matcher, sequencer, list.
// A letter is taken without a stall. The separator ending a callsign holds the input
// stalled through the divide state (which also runs the list compare), a state to read
// the hits, one to insert, the emit state (one character at a time) and the clear
// state. Keywords hold the input stalled through the emit and clear states only.
// Only one word is handled at a time; output stalls stretch emission.
// Reset (rst_n low, asynchronous): empty word, empty recent list, receiver_id 0.
module callsign_token_classifier #(
    parameter int MAX_TOKEN_LEN = 12,
    parameter int RECENT_DEPTH  = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic [15:0] confidence,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  receiver_tag,
    output logic        event_kind,
    output logic [7:0]  token_char,
    output logic [3:0]  char_pos,
    output logic        last_char,
    output logic [15:0] avg_confidence,
    output logic        first_sighting
);
    import cstc_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IW = $clog2(MAX_TOKEN_LEN);
    localparam int NCH = (MAX_TOKEN_LEN < CALL_MAX_LEN) ? MAX_TOKEN_LEN : CALL_MAX_LEN;

    cstc_state_t     state_reg, state_next;
    logic [7:0]      rx_id_reg;
    logic [7:0]      word_reg [MAX_TOKEN_LEN];
    logic [LW-1:0]   len_reg;
    logic            ovf_reg;
    logic [19:0]     sum_reg;
    logic            kind_reg;
    logic            fresh_reg;
    logic [15:0]     avg_reg;
    logic [LW-1:0]   pos_reg;
    logic            out_valid_reg;
    logic [7:0]      oc_reg;
    logic [3:0]      op_reg;
    logic            ol_reg;
    logic            ok_reg;
    logic [15:0]     oa_reg;
    logic            of_reg;

    logic            accept, is_sep, is_keep;
    logic [7:0]      cu;
    logic [15:0]     conf_c;

    // configuration is taken whenever written, so users must write it only while idle
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_id_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            rx_id_reg <= cfg_data;
        end
    end

    assign in_stall = (state_reg != ST_COLLECT);
    assign accept   = in_valid && !in_stall;
    assign cu       = (char_code >= 8'h61 && char_code <= 8'h7A) ? char_code - 8'd32 : char_code;
    assign is_sep   = (char_code == CH_SPACE) || (char_code == CH_TAB)
                      || (char_code == CH_CR) || (char_code == CH_LF);
    assign is_keep  = is_alnum(cu) || (cu == CH_SLASH);
    assign conf_c   = (confidence > CONF_ONE) ? CONF_ONE : confidence;

    // ---------------- callsign pattern, evaluated on the held word ----------
    logic [7:0] wc [16];
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            wc[i] = (i < MAX_TOKEN_LEN) ? word_reg[i % MAX_TOKEN_LEN] : 8'h0;
        end
    end

    // bytes beyond the length must not disturb the keyword compare
    logic [7:0] wk [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++) wk[i] = (i < int'(len_reg)) ? wc[i] : 8'h0;
    end

    function automatic logic side_ok(input logic [7:0] w [16], input int a, input int b);
        logic ok;
        ok = (b > a) && (b - a <= 4);
        for (int i = 0; i < 16; i++)
        begin
            if (i >= a && i < b && !is_alnum(w[i]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic main_ok(input logic [7:0] w [16], input int a, input int b);
        int  k;
        logic stop, ok;
        k = 0;
        stop = 1'b0;
        for (int j = 1; j <= 16; j++)
        begin
            if (!stop && (b - a >= j) && is_upper(w[(b - j) & 15]))
            begin
                k = j;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        ok = (k >= 1) && (k <= 4) && (b - a >= k + 2);
        if (ok)
        begin
            ok = is_digit(w[(b - 1 - k) & 15]) && (b - a - k - 1 <= 3)
                 && side_ok(w, a, a + (b - a - k - 1));
        end
        return ok;
    endfunction

    logic call_ok_c, kw_ok_c;
    always_comb
    begin
        int n, ns, s0, s1;
        n  = int'(len_reg);
        ns = 0;
        s0 = 0;
        s1 = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (i < n && wc[i] == CH_SLASH)
            begin
                if (ns == 0) s0 = i;
                else if (ns == 1) s1 = i;
                ns = ns + 1;
            end
        end
        if (n < 3 || n > CALL_MAX_LEN || ns > 2)
            call_ok_c = 1'b0;
        else if (ns == 0)
            call_ok_c = main_ok(wc, 0, n);
        else if (ns == 1)
            call_ok_c = (side_ok(wc, 0, s0) && main_ok(wc, s0 + 1, n))
                        || (main_ok(wc, 0, s0) && side_ok(wc, s0 + 1, n));
        else
            call_ok_c = side_ok(wc, 0, s0) && main_ok(wc, s0 + 1, s1)
                        && side_ok(wc, s1 + 1, n);

        kw_ok_c = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if ({{(8-LW){1'b0}}, len_reg} == 8'(kw_len(k))
                && {wk[0], wk[1], wk[2], wk[3]} == kw_text(k))
            begin
                if (len_reg <= LW'(KW_MAX)) kw_ok_c = 1'b1;
            end
        end
    end

    // ---------------- divider -----------------------------------------------
    logic        div_start, div_done;
    logic [15:0] div_q;
    cstc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (5'(len_reg)),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- recent list: chain of cells --------------------------
    cstc_chain_ctl_t        ctl;
    logic [NCH*8-1:0]       probe;
    logic                   cv  [RECENT_DEPTH+1];
    logic [NCH*8-1:0]       cc  [RECENT_DEPTH+1];
    logic [4:0]             cl  [RECENT_DEPTH+1];
    logic [RECENT_DEPTH-1:0] hits;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            probe[(NCH-1-i)*8 +: 8] = (i < int'(len_reg)) ? word_reg[i] : 8'h0;
        end
    end

    assign cv[0] = 1'b1;
    assign cc[0] = probe;
    assign cl[0] = 5'(len_reg);

    for (genvar g = 0; g < RECENT_DEPTH; g++)
    begin : g_cell
        cstc_recent_cell #(.NCH(NCH)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .prev_valid  (cv[g]),
            .prev_chars  (cc[g]),
            .prev_len    (cl[g]),
            .probe_chars (probe),
            .probe_len   (5'(len_reg)),
            .valid       (cv[g+1]),
            .chars       (cc[g+1]),
            .len         (cl[g+1]),
            .hit         (hits[g])
        );
    end

    // ---------------- sequencer ---------------------------------------------
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        ctl.search = 1'b0;
        ctl.shift  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && is_sep)
                begin
                    if (ovf_reg || len_reg == '0)
                        state_next = ST_CLEAR;
                    else if (call_ok_c)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else if (kw_ok_c)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_CLEAR;
                end
            end
            ST_DIVIDE:
            begin
                ctl.search = 1'b1;
                if (div_done) state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                // a fresh word enters the chain head; the oldest entry drops off the end
                ctl.shift  = fresh_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && pos_reg == len_reg - LW'(1)) state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                state_next = ST_COLLECT;
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_COLLECT:
                begin
                    pos_reg <= '0;
                    if (accept && !is_sep && is_keep && !ovf_reg)
                    begin
                        if (len_reg >= LW'(MAX_TOKEN_LEN))
                            ovf_reg <= 1'b1;
                        else
                        begin
                            len_reg <= len_reg + LW'(1);
                            sum_reg <= sum_reg + 20'(conf_c);
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        pos_reg <= pos_reg + LW'(1);
                    end
                end
                ST_CLEAR:
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                    sum_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COLLECT && accept && !is_sep && is_keep && !ovf_reg
            && len_reg < LW'(MAX_TOKEN_LEN))
        begin
            word_reg[len_reg[IW-1:0]] <= cu;
        end
        if (state_reg == ST_COLLECT && accept && is_sep)
        begin
            kind_reg  <= call_ok_c ? EV_CALLSIGN : EV_KEYWORD;
            avg_reg   <= 16'd0;
            fresh_reg <= 1'b0;
        end
        if (div_done) avg_reg <= div_q;
        if (state_reg == ST_SEARCH) fresh_reg <= (hits == '0);
        // load the whole result word so a stalled word holds while the next one builds
        if (state_reg == ST_EMIT && out_free)
        begin
            oc_reg <= word_reg[pos_reg[IW-1:0]];
            op_reg <= 4'(pos_reg);
            ol_reg <= (pos_reg == len_reg - LW'(1));
            ok_reg <= kind_reg;
            oa_reg <= avg_reg;
            of_reg <= fresh_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign receiver_tag   = rx_id_reg;
    assign event_kind     = ok_reg;
    assign token_char     = oc_reg;
    assign char_pos       = op_reg;
    assign last_char      = ol_reg;
    assign avg_confidence = oa_reg;
    assign first_sighting = of_reg;

    // emission only happens in the emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emission");
    // no input while a word is being classified
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_COLLECT |-> in_stall)
        else $error("input taken while busy");
    // word length never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_TOKEN_LEN))
        else $error("word length overflow");
endmodule
